>>> hw/rtl/bresenham_line_rasterizer_defines.svh
// ----------------------------------------------------------------------------
// Line rasterizer assertion macros
// Shared property wrappers used by the rasterizer RTL.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_RASTERIZER_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define BLR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define BLR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/blr_pkg.sv
// ----------------------------------------------------------------------------
// Line rasterizer package
// Widths, beat types, sequencer states and the difference unit result.
// ----------------------------------------------------------------------------
package blr_pkg;

   localparam int COORD_BITS = 6;
   localparam int ATTR_BITS  = 8;
   // The error stays within (-major_delta, minor_delta], two bits of headroom.
   localparam int ERR_BITS   = COORD_BITS + 2;
   localparam int ERR_EXT    = ERR_BITS - COORD_BITS;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [ATTR_BITS-1:0]  attr_type;
   typedef logic signed [ERR_BITS-1:0] err_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
      attr_type  line_color;
      attr_type  line_glyph;
   } req_type;

   typedef struct packed {
      coord_type pixel_x;
      coord_type pixel_y;
      attr_type  pixel_color;
      attr_type  pixel_glyph;
      logic      last_pixel;
   } rsp_type;

   typedef struct packed {
      coord_type diff;
      logic      a_gt_b;
      logic      a_lt_b;
   } absdiff_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DX,
      ST_DY,
      ST_ORDER,
      ST_MINOR,
      ST_WALK
   } state_type;

endpackage

>>> hw/rtl/blr_absdiff.sv
// ----------------------------------------------------------------------------
// Line rasterizer absolute difference unit
// Magnitude of a - b together with the ordering of the two operands.
// ----------------------------------------------------------------------------
module blr_absdiff
   import blr_pkg::*;
(
   input  coord_type   a,
   input  coord_type   b,
   output absdiff_type res
);

   logic gt;

   assign gt         = a > b;
   assign res.a_gt_b = gt;
   assign res.a_lt_b = a < b;
   assign res.diff   = gt ? (a - b) : (b - a);

endmodule

>>> hw/rtl/bresenham_line_rasterizer.sv
// ----------------------------------------------------------------------------
// Bresenham line rasterizer
// Turns one line command into its pixels, one result beat per pixel.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake             payload
//   req       in          req_valid/req_stall   req_type  (endpoints, color, glyph)
//   rsp       out         rsp_valid/rsp_stall   rsp_type  (pixel, color, glyph, last)
//
// A line is taken in with its command, then goes through four setup steps in
// the shared absolute difference unit (|dx|, |dy| and axis choice, endpoint
// order, minor delta), then gives one pixel per cycle unless rsp stalls.
// A new command is taken only when the previous line's walk has finished.
// Reset is synchronous and returns the sequencer to idle with no beat pending.
// A stall on rsp holds the walk; the last pixel may wait while setup of the
// next line goes on.
//
`include "bresenham_line_rasterizer_defines.svh"

module bresenham_line_rasterizer
   import blr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   state_type   state_ff, state_in;
   req_type     cmd_ff, cmd_in;
   coord_type   dx_ff, dx_in;
   coord_type   major_pos_ff, major_pos_in;
   coord_type   major_end_ff, major_end_in;
   coord_type   minor_pos_ff, minor_pos_in;
   coord_type   minor_end_ff, minor_end_in;
   coord_type   major_delta_ff, major_delta_in;
   coord_type   minor_delta_ff, minor_delta_in;
   logic        minor_down_ff, minor_down_in;
   logic        steep_ff, steep_in;
   err_type     err_ff, err_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;

   coord_type   unit_a, unit_b;
   absdiff_type unit_res;
   logic        accept;
   logic        load;
   logic        last;
   logic        steep_now;
   err_type     err_sum;

   blr_absdiff u_absdiff (
      .a   (unit_a),
      .b   (unit_b),
      .res (unit_res)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_DX;
         ST_DX:    state_in = ST_DY;
         ST_DY:    state_in = ST_ORDER;
         ST_ORDER: state_in = ST_MINOR;
         ST_MINOR: state_in = ST_WALK;
         ST_WALK:  if (load && last) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: handshake and operand selection for the shared unit.
   always_comb begin
      req_stall = 1'b1;
      load      = 1'b0;
      unit_a    = major_pos_ff;
      unit_b    = major_end_ff;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_DX: begin
            unit_a = cmd_ff.start_x;
            unit_b = cmd_ff.end_x;
         end
         ST_DY: begin
            unit_a = cmd_ff.start_y;
            unit_b = cmd_ff.end_y;
         end
         ST_ORDER: begin
            unit_a = major_pos_ff;
            unit_b = major_end_ff;
         end
         ST_MINOR: begin
            unit_a = minor_pos_ff;
            unit_b = minor_end_ff;
         end
         ST_WALK: begin
            load = !out_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign accept    = req_valid && !req_stall;
   assign last      = major_pos_ff == major_end_ff;
   assign steep_now = unit_res.diff > dx_ff;
   assign err_sum   = err_ff + $signed({{ERR_EXT{1'b0}}, minor_delta_ff});

   // Datapath.
   always_comb begin
      cmd_in         = cmd_ff;
      dx_in          = dx_ff;
      major_pos_in   = major_pos_ff;
      major_end_in   = major_end_ff;
      minor_pos_in   = minor_pos_ff;
      minor_end_in   = minor_end_ff;
      major_delta_in = major_delta_ff;
      minor_delta_in = minor_delta_ff;
      minor_down_in  = minor_down_ff;
      steep_in       = steep_ff;
      err_in         = err_ff;
      out_in         = out_ff;
      out_valid_in   = out_valid_ff && rsp_stall;

      if (accept) begin
         cmd_in = req_data;
      end

      case (state_ff)
         ST_DX: begin
            dx_in = unit_res.diff;
         end
         ST_DY: begin
            // A diagonal tie stays on the x axis.
            steep_in = steep_now;
            if (steep_now) begin
               major_pos_in = cmd_ff.start_y;
               major_end_in = cmd_ff.end_y;
               minor_pos_in = cmd_ff.start_x;
               minor_end_in = cmd_ff.end_x;
            end else begin
               major_pos_in = cmd_ff.start_x;
               major_end_in = cmd_ff.end_x;
               minor_pos_in = cmd_ff.start_y;
               minor_end_in = cmd_ff.end_y;
            end
         end
         ST_ORDER: begin
            major_delta_in = unit_res.diff;
            if (unit_res.a_gt_b) begin
               major_pos_in = major_end_ff;
               major_end_in = major_pos_ff;
               minor_pos_in = minor_end_ff;
               minor_end_in = minor_pos_ff;
            end
         end
         ST_MINOR: begin
            minor_delta_in = unit_res.diff;
            minor_down_in  = !unit_res.a_lt_b;
            err_in         = '0 - $signed({{ERR_EXT{1'b0}}, major_delta_ff >> 1});
         end
         ST_WALK: begin
            if (load) begin
               out_valid_in       = 1'b1;
               out_in.pixel_x     = steep_ff ? minor_pos_ff : major_pos_ff;
               out_in.pixel_y     = steep_ff ? major_pos_ff : minor_pos_ff;
               out_in.pixel_color = cmd_ff.line_color;
               out_in.pixel_glyph = cmd_ff.line_glyph;
               out_in.last_pixel  = last;
               if (err_sum > $signed({ERR_BITS{1'b0}})) begin
                  minor_pos_in = minor_down_ff ? (minor_pos_ff - 1'b1)
                                               : (minor_pos_ff + 1'b1);
                  err_in = err_sum - $signed({{ERR_EXT{1'b0}}, major_delta_ff});
               end else begin
                  err_in = err_sum;
               end
               if (!last) begin
                  major_pos_in = major_pos_ff + 1'b1;
               end
            end
         end
         default: begin
            err_in = err_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      dx_ff          <= dx_in;
      major_pos_ff   <= major_pos_in;
      major_end_ff   <= major_end_in;
      minor_pos_ff   <= minor_pos_in;
      minor_end_ff   <= minor_end_in;
      major_delta_ff <= major_delta_in;
      minor_delta_ff <= minor_delta_in;
      minor_down_ff  <= minor_down_in;
      steep_ff       <= steep_in;
      err_ff         <= err_in;
      out_ff         <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   `BLR_ASSERT_NEXT(a_accept_starts_setup, clock, reset, accept, state_ff == ST_DX, "accepted command did not start setup")
   `BLR_ASSERT_IMPLY(a_walk_within_end, clock, reset, state_ff == ST_WALK, major_pos_ff <= major_end_ff, "major position ran past the line end")
   `BLR_ASSERT_IMPLY(a_err_not_positive, clock, reset, state_ff == ST_WALK, err_ff <= $signed({ERR_BITS{1'b0}}), "error term positive during walk")
   `BLR_ASSERT_IMPLY(a_minor_delta_bounded, clock, reset, state_ff == ST_WALK, minor_delta_ff <= major_delta_ff, "minor delta exceeds major delta")
   `BLR_ASSERT_NEXT(a_last_ends_walk, clock, reset, state_ff == ST_WALK && load && last, state_ff == ST_IDLE, "walk went on past the last pixel")

endmodule
